// ===== src/nnsag_pkg.sv =====
// Package for the nearest-neighbor scale address generator.
// Holds the queue item type, command and register codes, and the back-end state type.
// No dependencies.
package nnsag_pkg;

    localparam int IDX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 2;
    localparam int S_TDATA_W  = 8;

    typedef enum logic {
        CMD_ADVANCE,
        CMD_RESTART
    } cmd_t;

    typedef struct packed {
        cmd_t kind;
        logic dims_zero;
    } item_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_DST_WIDTH,
        CFG_DST_HEIGHT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_MUL,
        ST_STEP
    } back_state_t;

endpackage

// ===== src/nnsag_front.sv =====
// Front end: accepts input items, classifies them and holds them in a two-entry queue.
// Depends on nnsag_pkg.
module nnsag_front #(
    parameter int DIM_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_restart,
    input  logic [DIM_BITS-1:0]  src_width,
    input  logic [DIM_BITS-1:0]  src_height,
    input  logic [DIM_BITS-1:0]  dst_width,
    input  logic [DIM_BITS-1:0]  dst_height,
    output logic                 q_valid,
    output nnsag_pkg::item_t     q_item,
    input  logic                 q_pop
);
    import nnsag_pkg::*;

    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam int PTR_W = $clog2(QDEPTH);

    item_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    item_t             new_item;

    assign s_tready = (count_reg != CNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;

    // Classify: command kind and whether the frame geometry is degenerate.
    always_comb begin
        new_item.kind      = s_restart ? CMD_RESTART : CMD_ADVANCE;
        new_item.dims_zero = (src_width == '0) || (src_height == '0) ||
                             (dst_width == '0) || (dst_height == '0);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== src/nnsag_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Does not import nnsag_pkg; no shared types used.
module nnsag_div #(
    parameter int W = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    output logic          done,
    output logic [W-1:0]  quot,
    output logic [W-1:0]  rem
);
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  divisor_reg, divisor_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign done    = done_reg;
    assign quot    = quot_reg;
    assign rem     = rem_reg;
    assign shifted = {rem_reg, quot_reg[W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = CW'(W - 1);
            quot_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end else if (busy_reg) begin
            // Subtract when it fits, shift the quotient bit in.
            if (!diff[W]) begin
                rem_next  = diff[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end else begin
                rem_next  = shifted[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

endmodule

// ===== src/nnsag_back.sv =====
// Back end: frame setup (divide, multiply) and per-pixel Bresenham stepping,
// with a registered result stage. Depends on nnsag_pkg and nnsag_div.
module nnsag_back #(
    parameter  int DIM_BITS = 12,
    localparam int TDATA_W  = ((nnsag_pkg::IDX_W + 2 * DIM_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  nnsag_pkg::item_t     q_item,
    output logic                 q_pop,
    input  logic [DIM_BITS-1:0]  src_width,
    input  logic [DIM_BITS-1:0]  src_height,
    input  logic [DIM_BITS-1:0]  dst_width,
    input  logic [DIM_BITS-1:0]  dst_height,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser
);
    import nnsag_pkg::*;

    localparam int D  = DIM_BITS;
    // Error terms can drift past 2*size when sizes shrink mid-frame; keep headroom.
    localparam int EW = 2 * DIM_BITS + 3;

    back_state_t             state_reg, state_next;
    logic [IDX_W-1:0]        row_base_reg, row_base_next;
    logic [IDX_W-1:0]        cur_index_reg, cur_index_next;
    logic signed [EW-1:0]    col_error_reg, col_error_next;
    logic signed [EW-1:0]    row_error_reg, row_error_next;
    logic [D-1:0]            col_skip_reg, col_skip_next;
    logic [IDX_W-1:0]        row_skip_reg, row_skip_next;
    logic [D:0]              col_inc_reg, col_inc_next;
    logic [D:0]              row_inc_reg, row_inc_next;
    logic [D-1:0]            x_reg, x_next;
    logic [D-1:0]            y_reg, y_next;
    logic                    frame_done_reg, frame_done_next;
    logic [D-1:0]            qy_reg, qy_next;

    logic                    out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]      out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;
    logic [1:0]              out_user_reg, out_user_next;

    logic                    div_start;
    logic                    div_x_done, div_y_done;
    logic [D-1:0]            qx, rx, qy, ry;
    logic [2*D-1:0]          row_prod;

    logic                    out_free;
    logic                    eol, eof;
    logic signed [EW-1:0]    two_dw, two_dh;
    logic signed [EW-1:0]    col_err_sum, row_err_sum;
    logic                    col_pos, row_pos;
    logic [IDX_W-1:0]        col_index_step;
    logic [IDX_W-1:0]        row_base_sum, row_base_step;
    logic                    step, emit, emit_valid;

    nnsag_div #(.W(D)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (src_width),
        .divisor  (dst_width),
        .done     (div_x_done),
        .quot     (qx),
        .rem      (rx)
    );

    nnsag_div #(.W(D)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (src_height),
        .divisor  (dst_height),
        .done     (div_y_done),
        .quot     (qy),
        .rem      (ry)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign row_prod = qy_reg * src_width;

    assign eol    = ({1'b0, x_reg} + (D+1)'(1)) >= {1'b0, dst_width};
    assign eof    = eol && (({1'b0, y_reg} + (D+1)'(1)) >= {1'b0, dst_height});
    assign two_dw = EW'({dst_width, 1'b0});
    assign two_dh = EW'({dst_height, 1'b0});

    assign col_err_sum    = col_error_reg + EW'(col_inc_reg);
    assign col_pos        = !col_err_sum[EW-1] && (col_err_sum != '0);
    assign col_index_step = cur_index_reg + IDX_W'(col_skip_reg) + IDX_W'(col_pos);

    assign row_err_sum    = row_error_reg + EW'(row_inc_reg);
    assign row_pos        = !row_err_sum[EW-1] && (row_err_sum != '0);
    assign row_base_sum   = row_base_reg + row_skip_reg;
    assign row_base_step  = row_base_sum + (row_pos ? IDX_W'(src_width) : '0);

    always_comb begin
        state_next      = state_reg;
        row_base_next   = row_base_reg;
        cur_index_next  = cur_index_reg;
        col_error_next  = col_error_reg;
        row_error_next  = row_error_reg;
        col_skip_next   = col_skip_reg;
        row_skip_next   = row_skip_reg;
        col_inc_next    = col_inc_reg;
        row_inc_next    = row_inc_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        frame_done_next = frame_done_reg;
        qy_next         = qy_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;
        step            = 1'b0;
        emit            = 1'b0;
        emit_valid      = 1'b0;

        unique case (state_reg)
            ST_RUN: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_item.kind == CMD_RESTART) begin
                        if (q_item.dims_zero) begin
                            emit            = 1'b1;
                            frame_done_next = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end else if (frame_done_reg) begin
                        emit = 1'b1;
                    end else if (q_item.dims_zero) begin
                        emit            = 1'b1;
                        frame_done_next = 1'b1;
                    end else begin
                        step = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_x_done && div_y_done) begin
                    // Shrinking axis: integer skip plus remainder; otherwise no skip.
                    if (dst_width < src_width) begin
                        col_skip_next = qx;
                        col_inc_next  = {rx, 1'b0};
                    end else begin
                        col_skip_next = '0;
                        col_inc_next  = {src_width, 1'b0};
                    end
                    if (dst_height < src_height) begin
                        qy_next      = qy;
                        row_inc_next = {ry, 1'b0};
                    end else begin
                        qy_next      = '0;
                        row_inc_next = {src_height, 1'b0};
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                row_skip_next   = IDX_W'(row_prod);
                col_error_next  = -two_dw;
                row_error_next  = -two_dh;
                row_base_next   = '0;
                cur_index_next  = '0;
                x_next          = '0;
                y_next          = '0;
                frame_done_next = 1'b0;
                state_next      = ST_STEP;
            end
            ST_STEP: begin
                if (out_free) begin
                    step       = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        if (step) begin
            emit       = 1'b1;
            emit_valid = 1'b1;
            if (eof) begin
                frame_done_next = 1'b1;
            end else if (!eol) begin
                cur_index_next = col_index_step;
                col_error_next = col_pos ? col_err_sum - two_dw : col_err_sum;
                x_next         = x_reg + 1'b1;
            end else begin
                row_base_next  = row_base_step;
                row_error_next = row_pos ? row_err_sum - two_dh : row_err_sum;
                cur_index_next = row_base_step;
                col_error_next = -two_dw;
                x_next         = '0;
                y_next         = y_reg + 1'b1;
            end
        end
    end

    // Result stage: load on emit, drop when taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = emit_valid ? TDATA_W'({y_reg, x_reg, cur_index_reg}) : '0;
            out_last_next  = emit_valid && eol;
            out_user_next  = {emit_valid, emit_valid && eof};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            row_base_reg   <= '0;
            cur_index_reg  <= '0;
            col_error_reg  <= '0;
            row_error_reg  <= '0;
            col_skip_reg   <= '0;
            row_skip_reg   <= '0;
            col_inc_reg    <= '0;
            row_inc_reg    <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            frame_done_reg <= 1'b1;
            qy_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_base_reg   <= row_base_next;
            cur_index_reg  <= cur_index_next;
            col_error_reg  <= col_error_next;
            row_error_reg  <= row_error_next;
            col_skip_reg   <= col_skip_next;
            row_skip_reg   <= row_skip_next;
            col_inc_reg    <= col_inc_next;
            row_inc_reg    <= row_inc_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            frame_done_reg <= frame_done_next;
            qy_reg         <= qy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== src/nearest_neighbor_scale_address_gen_top.sv =====
// An advance item passes from the queue into the result register; a restart item first runs
// the dividers for the skips, then latch, multiply, step.
// Throughput: one advance item per cycle while m_tready stays high; a restart holds the back end.
// Reset (aresetn low, synchronous): queue empty, no result pending, geometry registers back to
// 320x200 -> 80x50, and no frame active until the first restart.
// Depends on nnsag_pkg, nnsag_front, nnsag_div and nnsag_back.
module nearest_neighbor_scale_address_gen_top #(
    parameter  int DIM_BITS = 12,
    localparam int TDATA_W  = ((nnsag_pkg::IDX_W + 2 * DIM_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nnsag_pkg::S_TDATA_W-1:0]   s_tdata,      // [0] restart, rest zero
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDATA_W-1:0]                m_tdata,      // src_index, dst_x, dst_y
    output logic                              m_tlast,      // end_of_line
    output logic [1:0]                        m_tuser,      // end_of_frame, valid_res
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [nnsag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_BITS-1:0]               cfg_wr_data
);
    import nnsag_pkg::*;

    localparam logic [DIM_BITS-1:0] RST_SRC_WIDTH  = DIM_BITS'(320);
    localparam logic [DIM_BITS-1:0] RST_SRC_HEIGHT = DIM_BITS'(200);
    localparam logic [DIM_BITS-1:0] RST_DST_WIDTH  = DIM_BITS'(80);
    localparam logic [DIM_BITS-1:0] RST_DST_HEIGHT = DIM_BITS'(50);

    // Geometry registers. The back end reads them live; the user must change them only while idle (not enforced).
    logic [DIM_BITS-1:0] src_width_reg,  src_width_next;
    logic [DIM_BITS-1:0] src_height_reg, src_height_next;
    logic [DIM_BITS-1:0] dst_width_reg,  dst_width_next;
    logic [DIM_BITS-1:0] dst_height_reg, dst_height_next;

    logic   q_valid;
    logic   q_pop;
    item_t  q_item;

    always_comb begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        dst_width_next  = dst_width_reg;
        dst_height_next = dst_height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SRC_WIDTH:  src_width_next  = cfg_wr_data;
                CFG_SRC_HEIGHT: src_height_next = cfg_wr_data;
                CFG_DST_WIDTH:  dst_width_next  = cfg_wr_data;
                CFG_DST_HEIGHT: dst_height_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            dst_width_reg  <= RST_DST_WIDTH;
            dst_height_reg <= RST_DST_HEIGHT;
        end else begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            dst_width_reg  <= dst_width_next;
            dst_height_reg <= dst_height_next;
        end
    end

    // Front: accept and classify items, hold them in a short queue.
    nnsag_front #(.DIM_BITS(DIM_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_restart  (s_tdata[0]),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .dst_width  (dst_width_reg),
        .dst_height (dst_height_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back: frame setup and per-pixel stepping, registered result.
    nnsag_back #(.DIM_BITS(DIM_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .dst_width  (dst_width_reg),
        .dst_height (dst_height_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // An invalid result carries all-zero fields.
    a_invalid_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata == '0 && !m_tlast && !m_tuser[0]))
        else $error("invalid result with nonzero fields");

    // The last pixel of a frame is also the last pixel of its row and is valid.
    a_eof_is_eol : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tuser[1]))
        else $error("end of frame without end of line");

    // The queue never pops while empty.
    a_no_empty_pop : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the nearest-neighbor scale address generator.
// Drives restart/advance items, predicts every pixel address in-bench and compares the
// result stream field by field. Depends on nnsag_pkg and nearest_neighbor_scale_address_gen_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nnsag_pkg::*;

    localparam int DIM_W      = 12;
    localparam int M_TDATA_W  = 48;
    localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int HOLD_OFF   = 300;    // long receiver stall for the back-pressure test
    localparam int TAIL       = 16;     // settle cycles after the last result

    // One destination pixel as it leaves the block
    typedef struct {
        logic [IDX_W-1:0] src_index;
        logic [DIM_W-1:0] dst_x;
        logic [DIM_W-1:0] dst_y;
        logic             eol;
        logic             eof;
        logic             valid;
    } pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;     // [0] restart, rest zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // [23:0] src_index, [35:24] dst_x, [47:36] dst_y
    logic                  m_tlast;     // end_of_line
    logic [1:0]            m_tuser;     // [0] end_of_frame, [1] valid_res
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_wr_data;

    always #6 aclk = ~aclk;

    nearest_neighbor_scale_address_gen_top #(.DIM_BITS(DIM_W)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Scaler model state: geometry copy plus the Bresenham stepping state
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  src_w = 12'd320;
    logic [DIM_W-1:0]  src_h = 12'd200;
    logic [DIM_W-1:0]  dst_w = 12'd80;
    logic [DIM_W-1:0]  dst_h = 12'd50;

    logic [IDX_W-1:0]  row_base = '0;
    logic [IDX_W-1:0]  cur_index = '0;
    int                col_err = 0;
    int                row_err = 0;
    logic [DIM_W-1:0]  col_skip = '0;
    logic [IDX_W-1:0]  row_skip_pix = '0;
    int unsigned       col_inc = 0;
    int unsigned       row_inc = 0;
    logic [DIM_W-1:0]  x_cnt = '0;
    logic [DIM_W-1:0]  y_cnt = '0;
    bit                frame_done = 1'b1;   // no frame active until the first restart

    pixel_t            pixel_q[$];          // pixels still owed by the block
    int                err_cnt = 0;
    int                idle_cycles = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    bit                holding = 1'b0;
    event              hold_off_ev;

    // Work out the pixel one item produces and advance the stepping state.
    function automatic pixel_t predict_pixel(cmd_t kind);
        pixel_t      p;
        bit          zero_dim;
        bit          eol;
        bit          eof;
        int unsigned ddx, ddx1, ddy, ddy1;
        p = '{default: '0};
        zero_dim = (src_w == 0) || (src_h == 0) || (dst_w == 0) || (dst_h == 0);
        if (kind == CMD_RESTART) begin
            if (zero_dim) begin
                frame_done = 1'b1;
                return p;
            end
            ddx  = 2 * src_w;
            ddx1 = 2 * dst_w;
            ddy  = 2 * src_h;
            ddy1 = 2 * dst_h;
            // shrinking axis: integer skip plus remainder; growing axis: plain increment
            if (ddx1 < ddx) begin
                col_skip = DIM_W'(ddx / ddx1);
                col_inc  = ddx % ddx1;
            end else begin
                col_skip = '0;
                col_inc  = ddx;
            end
            if (ddy1 < ddy) begin
                row_skip_pix = IDX_W'((ddy / ddy1) * src_w);
                row_inc      = ddy % ddy1;
            end else begin
                row_skip_pix = '0;
                row_inc      = ddy;
            end
            col_err    = -int'(ddx1);
            row_err    = -int'(ddy1);
            row_base   = '0;
            cur_index  = '0;
            x_cnt      = '0;
            y_cnt      = '0;
            frame_done = 1'b0;
        end else if (frame_done) begin
            return p;
        end else if (zero_dim) begin
            frame_done = 1'b1;
            return p;
        end

        // end tests read the live sizes, so a shrunk size ends the row/frame at once
        eol = (x_cnt + 1) >= dst_w;
        eof = eol && ((y_cnt + 1) >= dst_h);
        p.src_index = cur_index;
        p.dst_x     = x_cnt;
        p.dst_y     = y_cnt;
        p.eol       = eol;
        p.eof       = eof;
        p.valid     = 1'b1;

        if (eof) begin
            frame_done = 1'b1;
        end else if (!eol) begin
            cur_index = cur_index + col_skip;
            col_err += int'(col_inc);
            if (col_err > 0) begin
                cur_index = cur_index + 1'b1;
                col_err -= int'(2 * dst_w);
            end
            x_cnt = x_cnt + 1'b1;
        end else begin
            row_base = row_base + row_skip_pix;
            row_err += int'(row_inc);
            if (row_err > 0) begin
                row_base = row_base + src_w;
                row_err -= int'(2 * dst_h);
            end
            cur_index = row_base;
            col_err   = -int'(2 * dst_w);
            x_cnt     = '0;
            y_cnt     = y_cnt + 1'b1;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (holding)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Count the hold-off here so the sender keeps offering items meanwhile
    initial begin
        forever begin
            @(hold_off_ev);
            holding = 1'b1;
            repeat (HOLD_OFF) @(posedge aclk);
            holding = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted pixel with the oldest expected one
    // ------------------------------------------------------------------
    task automatic report(string field, longint unsigned exp_v, longint unsigned act_v);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        pixel_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected pixel, expected none actual %h/%b/%b", $time,
                         m_tdata, m_tlast, m_tuser);
                err_cnt++;
            end else begin
                exp_p = pixel_q.pop_front();
                if (m_tdata[23:0] !== exp_p.src_index)
                    report("src_index", exp_p.src_index, m_tdata[23:0]);
                if (m_tdata[35:24] !== exp_p.dst_x)
                    report("dst_x", exp_p.dst_x, m_tdata[35:24]);
                if (m_tdata[47:36] !== exp_p.dst_y)
                    report("dst_y", exp_p.dst_y, m_tdata[47:36]);
                if (m_tlast !== exp_p.eol)
                    report("end_of_line", exp_p.eol, m_tlast);
                if (m_tuser[0] !== exp_p.eof)
                    report("end_of_frame", exp_p.eof, m_tuser[0]);
                if (m_tuser[1] !== exp_p.valid)
                    report("valid_res", exp_p.valid, m_tuser[1]);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d pixels outstanding", $time,
                     pixel_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers; each task starts and ends right after a rising edge
    // ------------------------------------------------------------------
    task automatic send_item(cmd_t kind);
        // idle the sender at random before offering the item
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, kind};
        do @(posedge aclk); while (!s_tready);
        pixel_q.push_back(predict_pixel(kind));
    endtask

    // Drop valid and wait until every owed pixel has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pixel_q.size() != 0);
    endtask

    // Write all four geometry registers; call only while the block is idle
    task automatic set_geometry(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                                logic [DIM_W-1:0] dw, logic [DIM_W-1:0] dh);
        logic [DIM_W-1:0] vals[4];
        vals = '{sw, sh, dw, dh};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= cfg_idx_t'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        src_w = sw;
        src_h = sh;
        dst_w = dw;
        dst_h = dh;
    endtask

    task automatic send_advances(int n);
        repeat (n) send_item(CMD_ADVANCE);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Advance before any restart: invalid pixel, nothing changes
    task automatic test_advance_before_restart();
        send_item(CMD_ADVANCE);
        drain();
    endtask

    // Reset geometry 320x200 -> 80x50, first few pixels
    task automatic test_reset_geometry();
        send_item(CMD_RESTART);
        send_advances(3);
        drain();
    endtask

    // Any zero register invalidates a restart; an advance afterwards stays invalid
    task automatic test_zero_dims();
        set_geometry(12'd0, 12'd4, 12'd2, 12'd2);
        send_item(CMD_RESTART);
        drain();
        set_geometry(12'd4, 12'd0, 12'd2, 12'd2);
        send_item(CMD_RESTART);
        drain();
        set_geometry(12'd4, 12'd4, 12'd0, 12'd2);
        send_item(CMD_RESTART);
        drain();
        set_geometry(12'd4, 12'd4, 12'd2, 12'd0);
        send_item(CMD_RESTART);
        send_item(CMD_ADVANCE);
        drain();
    endtask

    // Full-scale source into a single pixel: frame ends at once, then advance is invalid
    task automatic test_finished_frame();
        set_geometry(12'd4095, 12'd4095, 12'd1, 12'd1);
        send_item(CMD_RESTART);
        send_item(CMD_ADVANCE);
        drain();
    endtask

    // Heavy shrink on both axes, then enlarge a single source pixel
    task automatic test_shrink_and_grow();
        set_geometry(12'd4095, 12'd4095, 12'd2, 12'd2);
        send_item(CMD_RESTART);
        send_advances(3);
        drain();
        set_geometry(12'd1, 12'd1, 12'd2, 12'd2);
        send_item(CMD_RESTART);
        send_advances(3);
        drain();
    endtask

    // Shrink the live sizes mid-frame: row ends early, then a zero height kills the frame
    task automatic test_midframe_change();
        set_geometry(12'd7, 12'd5, 12'd3, 12'd3);
        send_item(CMD_RESTART);
        send_advances(2);
        drain();
        set_geometry(12'd7, 12'd5, 12'd1, 12'd3);
        send_item(CMD_ADVANCE);
        drain();
        set_geometry(12'd7, 12'd5, 12'd1, 12'd0);
        send_item(CMD_ADVANCE);
        drain();
    endtask

    // Hold the receiver off for a long stretch so the block fills and stalls its input
    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_geometry(12'd23, 12'd17, 12'd10, 12'd10);
        -> hold_off_ev;
        send_item(CMD_RESTART);
        send_advances(60);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Random frames: mostly complete small frames, some large, some noise
    // ------------------------------------------------------------------
    task automatic test_random_frames(int n_items, int snd_pct, int rcv_pct);
        int          sent;
        int          sel;
        int          len;
        int          extra;
        int          style;
        int unsigned npix;
        logic [DIM_W-1:0] g[4];
        sent = 0;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        while (sent < n_items) begin
            // keep the geometry now and then so restarts follow frames back to back
            if ($urandom_range(3) != 0) begin
                sel = $urandom_range(99);
                if (sel < 12) begin
                    for (int i = 0; i < 4; i++) g[i] = DIM_W'($urandom_range(1, 4095));
                end else begin
                    g[0] = DIM_W'($urandom_range(0, 1) ? $urandom_range(1, 4095)
                                                       : $urandom_range(1, 40));
                    g[1] = DIM_W'($urandom_range(0, 1) ? $urandom_range(1, 4095)
                                                       : $urandom_range(1, 40));
                    g[2] = DIM_W'($urandom_range(1, 8));
                    g[3] = DIM_W'($urandom_range(1, 8));
                end
                if (sel >= 94)
                    g[$urandom_range(3)] = '0;
                drain();
                set_geometry(g[0], g[1], g[2], g[3]);
            end
            send_item(CMD_RESTART);
            sent++;
            npix  = dst_w * dst_h;
            len   = (npix == 0) ? $urandom_range(0, 2) : ((npix > 61) ? 60 : npix - 1);
            style = $urandom_range(9);
            if (style == 0) begin
                // noise: random mix of restarts and advances
                len = $urandom_range(1, 20);
                repeat (len) send_item(cmd_t'($urandom_range(0, 1)));
            end else begin
                // broken sequence cuts the frame short; otherwise run it out
                if (style == 1 && len > 0)
                    len = $urandom_range(0, len - 1);
                send_advances(len);
                // a few advances past the end of the frame
                extra = $urandom_range(0, 2);
                send_advances(extra);
                len += extra;
            end
            sent += len;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= cfg_idx_t'(CFG_SRC_WIDTH);
        cfg_wr_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_advance_before_restart();
        test_reset_geometry();
        test_zero_dims();
        test_finished_frame();
        test_shrink_and_grow();
        test_midframe_change();
        test_back_pressure();

        // idling phases: none, sender 65%, receiver 65%, both 10%
        test_random_frames(500, 0, 0);
        test_random_frames(500, 65, 0);
        test_random_frames(500, 0, 65);
        test_random_frames(500, 10, 10);

        drain();
        repeat (TAIL) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
